/* hw/rtl/rgbc_pkg.sv */
`timescale 1ns / 1ps

package rgbc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int COEFF_BITS_DEF = 8;
    localparam int KSIZE          = 3;
    localparam int NUM_CH         = 3;
    localparam int CH_BITS        = 8;
    localparam int PIX_BITS       = NUM_CH * CH_BITS;
    localparam int PIX_MAX        = 255;

    localparam int IMGW_CFG_BITS  = 11;
    localparam int IMGH_CFG_BITS  = 13;
    localparam int KROW_BITS      = 24;
    localparam int MAX_HEIGHT     = 4096;
    localparam int HGT_BITS       = 13;
    localparam int ROW_BITS       = 14;

    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam int RST_IMG_WIDTH  = 1024;
    localparam int RST_IMG_HEIGHT = 1;
    localparam logic [KROW_BITS-1:0] RST_KROW_TOP = 24'd0;
    localparam logic [KROW_BITS-1:0] RST_KROW_MID = 24'd256;
    localparam logic [KROW_BITS-1:0] RST_KROW_BOT = 24'd0;

    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMG_WIDTH  = 3'd0,
        CFG_IMG_HEIGHT = 3'd1,
        CFG_KROW_TOP   = 3'd2,
        CFG_KROW_MID   = 3'd3,
        CFG_KROW_BOT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                produce;
        logic                last;
        logic [KSIZE-1:0]    row_ok;
        logic [KSIZE-1:0]    col_ok;
    } t_ctl;

    typedef struct packed {
        logic [PIX_BITS-1:0] upper;
        logic [PIX_BITS-1:0] lower;
    } t_ls_ent;

    typedef struct packed {
        logic [PIX_BITS-1:0] upper;
        logic [PIX_BITS-1:0] lower;
        logic [PIX_BITS-1:0] cur;
    } t_col;

    typedef struct packed {
        logic [CH_BITS-1:0] res_a;
        logic [CH_BITS-1:0] res_b;
        logic [CH_BITS-1:0] res_c;
        logic               last_pixel;
    } t_res;

endpackage

/* hw/rtl/rgbc_pix_if.sv */
`timescale 1ns / 1ps

interface rgbc_pix_if;
    import rgbc_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [CH_BITS-1:0] chan_a;
    logic [CH_BITS-1:0] chan_b;
    logic [CH_BITS-1:0] chan_c;

    modport source (output valid, output operation, output chan_a, output chan_b,
                    output chan_c, input ready);
    modport sink   (input valid, input operation, input chan_a, input chan_b,
                    input chan_c, output ready);
endinterface

/* hw/rtl/rgbc_res_if.sv */
`timescale 1ns / 1ps

interface rgbc_res_if;
    import rgbc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_BITS-1:0] res_a;
    logic [CH_BITS-1:0] res_b;
    logic [CH_BITS-1:0] res_c;
    logic               last_pixel;

    modport source (output valid, output res_a, output res_b, output res_c,
                    output last_pixel, input ready);
    modport sink   (input valid, input res_a, input res_b, input res_c,
                    input last_pixel, output ready);
endinterface

/* hw/rtl/rgbc_line_buf.sv */
`timescale 1ns / 1ps

module rgbc_line_buf #(
    parameter int MAX_WIDTH = rgbc_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_addr,
    input  logic [rgbc_pkg::PIX_BITS-1:0]  i_pix,
    output logic                           o_col_valid,
    output rgbc_pkg::t_col                 o_col
);
    import rgbc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    t_ls_ent             r_mem [MAX_WIDTH];
    t_ls_ent             r_rd;
    t_ls_ent             r_fwd_data;
    logic                r_fwd;
    logic                r_wb_v;
    logic [AW-1:0]       r_wb_addr;
    logic [PIX_BITS-1:0] r_wb_pix;
    t_ls_ent             eff;
    t_ls_ent             wb_data;

    // column entry seen by the transaction now in stage 1
    assign eff     = r_fwd ? r_fwd_data : r_rd;
    assign wb_data = '{upper: eff.lower, lower: r_wb_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_v <= 1'b0;
        end else begin
            r_wb_v <= i_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wb_v) begin
            r_mem[r_wb_addr] <= wb_data;
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_addr];
            r_fwd      <= r_wb_v && (i_addr == r_wb_addr);
            r_fwd_data <= wb_data;
            r_wb_addr  <= i_addr;
            r_wb_pix   <= i_pix;
        end
    end

    assign o_col_valid = r_wb_v;
    assign o_col       = '{upper: eff.upper, lower: eff.lower, cur: r_wb_pix};

endmodule

/* hw/rtl/rgbc_conv.sv */
`timescale 1ns / 1ps

module rgbc_conv #(
    parameter int COEFF_BITS = rgbc_pkg::COEFF_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_col_valid,
    input  rgbc_pkg::t_col                 i_col,
    input  rgbc_pkg::t_ctl                 i_ctl,
    input  logic [rgbc_pkg::KROW_BITS-1:0] i_krow_top,
    input  logic [rgbc_pkg::KROW_BITS-1:0] i_krow_mid,
    input  logic [rgbc_pkg::KROW_BITS-1:0] i_krow_bot,
    output logic                           o_s2_valid,
    output logic                           o_res_valid,
    output rgbc_pkg::t_res                 o_res
);
    import rgbc_pkg::*;

    localparam int PW  = COEFF_BITS + CH_BITS + 1;
    localparam int SW  = PW + 4;
    localparam int KXW = KSIZE * COEFF_BITS + KROW_BITS;

    logic [PIX_BITS-1:0]          r_win [KSIZE][KSIZE];
    logic [PIX_BITS-1:0]          n_win [KSIZE][KSIZE];
    logic signed [COEFF_BITS-1:0] coef  [KSIZE][KSIZE];
    logic [KXW-1:0]               kx    [KSIZE];
    logic signed [PW-1:0]         n_prod [NUM_CH][KSIZE][KSIZE];
    logic signed [PW-1:0]         r_prod [NUM_CH][KSIZE][KSIZE];
    logic                         r_s2_valid;
    logic                         r_s2_last;
    logic signed [SW-1:0]         sum   [NUM_CH];
    logic [CH_BITS-1:0]           clip  [NUM_CH];

    assign kx[0] = KXW'(i_krow_top);
    assign kx[1] = KXW'(i_krow_mid);
    assign kx[2] = KXW'(i_krow_bot);

    always_comb begin
        for (int i = 0; i < KSIZE; i++) begin
            for (int j = 0; j < KSIZE; j++) begin
                coef[i][j] = kx[i][j*COEFF_BITS +: COEFF_BITS];
            end
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = i_col.upper;
        n_win[1][2] = i_col.lower;
        n_win[2][2] = i_col.cur;
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE; j++) begin
                    if (i_ctl.row_ok[i] && i_ctl.col_ok[j]) begin
                        n_prod[ch][i][j] =
                            $signed({1'b0, n_win[i][j][ch*CH_BITS +: CH_BITS]}) * coef[i][j];
                    end else begin
                        n_prod[ch][i][j] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_s2_valid <= i_col_valid && i_ctl.produce;
            if (i_col_valid) begin
                for (int i = 0; i < KSIZE; i++) begin
                    for (int j = 0; j < KSIZE; j++) begin
                        // window restarts after the final pixel of an image
                        r_win[i][j] <= (i_ctl.produce && i_ctl.last) ? '0 : n_win[i][j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_col_valid) begin
            r_prod    <= n_prod;
            r_s2_last <= i_ctl.last;
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum[ch] = '0;
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE; j++) begin
                    sum[ch] = sum[ch] + SW'(r_prod[ch][i][j]);
                end
            end
            if (sum[ch] < 0) begin
                clip[ch] = '0;
            end else if (sum[ch] > $signed(SW'(PIX_MAX))) begin
                clip[ch] = CH_BITS'(PIX_MAX);
            end else begin
                clip[ch] = sum[ch][CH_BITS-1:0];
            end
        end
    end

    assign o_s2_valid  = r_s2_valid;
    assign o_res_valid = r_s2_valid;
    assign o_res       = '{res_a: clip[0], res_b: clip[1], res_c: clip[2],
                           last_pixel: r_s2_last};

endmodule

/* hw/rtl/rgbc_res_fifo.sv */
`timescale 1ns / 1ps

module rgbc_res_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_valid,
    input  rgbc_pkg::t_res                     i_wr_data,
    rgbc_res_if.source                         o_res,
    output logic [rgbc_pkg::FIFO_CNT_BITS-1:0] o_count
);
    import rgbc_pkg::*;

    t_res                     r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wp;
    logic [FIFO_PTR_BITS-1:0] r_rp;
    logic [FIFO_CNT_BITS-1:0] r_cnt;
    logic                     pop;
    t_res                     head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + FIFO_CNT_BITS'(i_wr_valid) - FIFO_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_valid) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    assign o_res.valid      = (r_cnt != '0);
    assign o_res.res_a      = head.res_a;
    assign o_res.res_b      = head.res_b;
    assign o_res.res_c      = head.res_c;
    assign o_res.last_pixel = head.last_pixel;
    assign o_count          = r_cnt;

endmodule

/* hw/rtl/rgb_3x3_convolution_clamped_unit.sv */
`timescale 1ns / 1ps

// Streaming 3x3 convolution of RGB pixels with zero padding and 0..255 clamping. One
// transaction is taken per clock: a pixel transaction is read against two column-indexed
// line stores (one memory of MAX_WIDTH entries, read and written once per clock), goes
// through a window/multiply stage and a sum/clamp stage, and lands in a four-entry result
// queue. The input stalls only while that queue plus the two stages in flight are full.
// In pixel terms results lag the input by image_width+1 positions, so after the last
// pixel image_width+1 flush transactions release the remaining results (on a single-row
// image the first of them gives nothing); the last one carries last_pixel. A flush before
// the image is complete is taken and dropped. Configuration is to be written only while
// the unit is idle; the unit itself does not enforce this. The line stores need no
// clearing after reset.
module rgb_3x3_convolution_clamped_unit #(
    parameter int MAX_WIDTH  = rgbc_pkg::MAX_WIDTH_DEF,
    parameter int COEFF_BITS = rgbc_pkg::COEFF_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rgbc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [rgbc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    rgbc_pix_if.sink                           i_pix,
    rgbc_res_if.source                         o_res
);
    import rgbc_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int TW = WW + HGT_BITS;

    function automatic logic [WW-1:0] f_eff_w(input logic [IMGW_CFG_BITS-1:0] v);
        logic [WW-1:0] r;
        if (v == '0) begin
            r = WW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            r = WW'(MAX_WIDTH);
        end else begin
            r = WW'(v);
        end
        return r;
    endfunction

    function automatic logic [HGT_BITS-1:0] f_eff_h(input logic [IMGH_CFG_BITS-1:0] v);
        logic [HGT_BITS-1:0] r;
        if (v == '0) begin
            r = HGT_BITS'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = HGT_BITS'(MAX_HEIGHT);
        end else begin
            r = HGT_BITS'(v);
        end
        return r;
    endfunction

    logic [WW-1:0]            r_eff_w;
    logic [HGT_BITS-1:0]      r_eff_h;
    logic [TW-1:0]            r_total;
    logic [KROW_BITS-1:0]     r_krow_top;
    logic [KROW_BITS-1:0]     r_krow_mid;
    logic [KROW_BITS-1:0]     r_krow_bot;
    logic [ROW_BITS-1:0]      r_in_row;
    logic [XW-1:0]            r_in_col;
    logic [TW-1:0]            r_out_cnt;
    t_ctl                     r_s1_ctl;

    logic [WW-1:0]            cfg_w;
    logic [HGT_BITS-1:0]      cfg_h;
    logic [TW-1:0]            tot_w;
    logic [TW-1:0]            tot_h;

    logic                     flushing;
    logic                     ignore;
    logic                     fire;
    logic [PIX_BITS-1:0]      pix;
    logic                     col_nz;
    logic [WW-1:0]            col_p1;
    logic                     wrap;
    logic [WW-1:0]            ccol;
    logic [WW:0]              ccol_x;
    logic [WW:0]              w_x;
    logic [ROW_BITS-1:0]      crow;
    logic [ROW_BITS:0]        crow_x;
    logic [ROW_BITS:0]        h_x;
    logic                     produce;
    logic [TW-1:0]            cnt_p1;
    logic                     last;
    t_ctl                     n_ctl;

    logic                     col_valid;
    t_col                     col;
    logic                     s2_valid;
    logic                     res_valid;
    t_res                     res;
    logic [FIFO_CNT_BITS-1:0] fifo_cnt;
    logic [FIFO_CNT_BITS-1:0] pending;

    assign cfg_w = f_eff_w(i_cfg_data[IMGW_CFG_BITS-1:0]);
    assign cfg_h = f_eff_h(i_cfg_data[IMGH_CFG_BITS-1:0]);
    assign tot_w = TW'(cfg_w) * TW'(r_eff_h);
    assign tot_h = TW'(r_eff_w) * TW'(cfg_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w    <= f_eff_w(IMGW_CFG_BITS'(RST_IMG_WIDTH));
            r_eff_h    <= f_eff_h(IMGH_CFG_BITS'(RST_IMG_HEIGHT));
            r_total    <= TW'(f_eff_w(IMGW_CFG_BITS'(RST_IMG_WIDTH)))
                          * TW'(f_eff_h(IMGH_CFG_BITS'(RST_IMG_HEIGHT)));
            r_krow_top <= RST_KROW_TOP;
            r_krow_mid <= RST_KROW_MID;
            r_krow_bot <= RST_KROW_BOT;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMG_WIDTH: begin
                    r_eff_w <= cfg_w;
                    r_total <= tot_w;
                end
                CFG_IMG_HEIGHT: begin
                    r_eff_h <= cfg_h;
                    r_total <= tot_h;
                end
                CFG_KROW_TOP: r_krow_top <= i_cfg_data[KROW_BITS-1:0];
                CFG_KROW_MID: r_krow_mid <= i_cfg_data[KROW_BITS-1:0];
                CFG_KROW_BOT: r_krow_bot <= i_cfg_data[KROW_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign flushing = r_in_row >= ROW_BITS'(r_eff_h);
    assign ignore   = i_pix.operation && !flushing;
    assign fire     = i_pix.valid && i_pix.ready && !ignore;
    assign pix      = flushing ? '0 : {i_pix.chan_c, i_pix.chan_b, i_pix.chan_a};

    assign col_nz  = (r_in_col != '0);
    assign col_p1  = WW'(r_in_col) + WW'(1);
    assign wrap    = (col_p1 >= r_eff_w) || (col_p1 == WW'(MAX_WIDTH));
    assign ccol    = col_nz ? (WW'(r_in_col) - WW'(1)) : (r_eff_w - WW'(1));
    assign ccol_x  = {1'b0, ccol};
    assign w_x     = {1'b0, r_eff_w};
    assign produce = col_nz ? (r_in_row >= ROW_BITS'(1)) : (r_in_row >= ROW_BITS'(2));
    assign crow    = col_nz ? (r_in_row - ROW_BITS'(1)) : (r_in_row - ROW_BITS'(2));
    assign crow_x  = {1'b0, crow};
    assign h_x     = (ROW_BITS + 1)'(r_eff_h);
    assign cnt_p1  = r_out_cnt + TW'(1);
    assign last    = cnt_p1 >= r_total;

    always_comb begin
        n_ctl.produce   = produce;
        n_ctl.last      = last;
        n_ctl.row_ok[0] = (crow != '0) && ((crow_x - 1'b1) < h_x);
        n_ctl.row_ok[1] = crow_x < h_x;
        n_ctl.row_ok[2] = (crow_x + 1'b1) < h_x;
        n_ctl.col_ok[0] = (ccol != '0) && ((ccol_x - 1'b1) < w_x);
        n_ctl.col_ok[1] = ccol_x < w_x;
        n_ctl.col_ok[2] = (ccol_x + 1'b1) < w_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_cnt <= '0;
        end else if (fire) begin
            if (produce && last) begin
                r_in_row  <= '0;
                r_in_col  <= '0;
                r_out_cnt <= '0;
            end else begin
                if (wrap) begin
                    r_in_col <= '0;
                    if (!(&r_in_row)) begin
                        r_in_row <= r_in_row + ROW_BITS'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + XW'(1);
                end
                if (produce) begin
                    r_out_cnt <= cnt_p1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_ctl <= n_ctl;
        end
    end

    // queue slots are reserved for transactions still in the two stages
    assign pending     = fifo_cnt + FIFO_CNT_BITS'(col_valid) + FIFO_CNT_BITS'(s2_valid);
    assign i_pix.ready = pending < FIFO_CNT_BITS'(FIFO_DEPTH);

    rgbc_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (fire),
        .i_addr      (r_in_col),
        .i_pix       (pix),
        .o_col_valid (col_valid),
        .o_col       (col)
    );

    rgbc_conv #(
        .COEFF_BITS (COEFF_BITS)
    ) u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col_valid (col_valid),
        .i_col       (col),
        .i_ctl       (r_s1_ctl),
        .i_krow_top  (r_krow_top),
        .i_krow_mid  (r_krow_mid),
        .i_krow_bot  (r_krow_bot),
        .o_s2_valid  (s2_valid),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rgbc_res_fifo u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (res_valid),
        .i_wr_data  (res),
        .o_res      (o_res),
        .o_count    (fifo_cnt)
    );

endmodule
